// File: sv/rbsd_pkg.sv
package rbsd_pkg;

  localparam int unsigned SCREEN_COLUMNS = 128;
  localparam int unsigned SCREEN_PAGES   = 8;
  localparam int unsigned SPAN_CAP       = 9;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       image_start;
    logic [7:0] origin_col;
    logic [7:0] origin_page;
  } in_word_t;

  typedef struct packed {
    logic [2:0] span_page;
    logic [6:0] span_col;
    logic [7:0] span_len;
    logic [7:0] bar_value;
    logic       image_done;
    logic [7:0] image_width;
    logic       last_of_byte;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } ctrl_cmd_t;

  typedef struct packed {
    logic no_bars;
    logic last_bar;
    logic step_ok;
    logic flush_ok;
  } ctrl_sts_t;

endpackage

// File: sv/rbsd_ctrl.sv
module rbsd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rbsd_pkg::ctrl_sts_t sts,
  output rbsd_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_WAIT,
    ST_BARS,
    ST_FLUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    in_ready  = (state_r == ST_WAIT) || ((state_r == ST_FLUSH) && sts.flush_ok);
    cmd.load  = in_valid && in_ready;
    cmd.step  = (state_r == ST_BARS) && !sts.no_bars && sts.step_ok;
    cmd.flush = (state_r == ST_FLUSH) && sts.flush_ok;
    state_nxt = state_r;
    case (state_r)
      ST_WAIT: begin
        if (cmd.load) state_nxt = ST_BARS;
      end
      ST_BARS: begin
        if (sts.no_bars || (cmd.step && sts.last_bar)) state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (cmd.flush) state_nxt = cmd.load ? ST_BARS : ST_WAIT;
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step && cmd.flush)) else $error("step and flush together");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == ST_WAIT || cmd.flush)) else $error("load while busy");

  a_bars_to_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BARS && sts.no_bars) |=> state_r == ST_FLUSH)
    else $error("bar phase did not end");

endmodule

// File: sv/rbsd_datapath.sv
module rbsd_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  rbsd_pkg::in_word_t  in_word,
  input  rbsd_pkg::ctrl_cmd_t cmd,
  output rbsd_pkg::ctrl_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output rbsd_pkg::out_word_t out_word
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PAGES,
    PH_TOKEN,
    PH_RUNBYTE,
    PH_LITERAL
  } phase_t;

  phase_t     phase_r;
  phase_t     phase_eff;
  logic [7:0] img_width_r;
  logic [7:0] img_pages_r;
  logic [7:0] base_col_r;
  logic [7:0] base_page_r;
  logic [7:0] cur_col_r;
  logic [7:0] cur_page_r;
  logic [6:0] literal_left_r;
  logic [6:0] run_count_r;
  logic [6:0] bars_left_r;
  logic [7:0] bar_r;
  logic       boundary_r;

  logic       pend_valid_r;
  logic [7:0] pend_page_r;
  logic [7:0] pend_col_r;
  logic [7:0] pend_len_r;
  logic [7:0] pend_bar_r;
  logic [3:0] span_cnt_r;

  logic                out_valid_r;
  rbsd_pkg::out_word_t out_word_r;
  rbsd_pkg::out_word_t emit_word;

  logic       visible;
  logic [8:0] col_sum;
  logic       merge;
  logic       room;
  logic       start_new;
  logic       step_emit;
  logic [7:0] col_inc;
  logic [7:0] col_off;
  logic       wrap;
  logic [7:0] page_off;
  logic       done_now;
  logic       flush_emit;
  logic       out_free;
  logic       emit;
  logic [6:0] lit_dec;

  always_comb begin
    visible   = (cur_page_r < 8'(rbsd_pkg::SCREEN_PAGES)) &&
                (cur_col_r < 8'(rbsd_pkg::SCREEN_COLUMNS));
    col_sum   = {1'b0, pend_col_r} + {1'b0, pend_len_r};
    merge     = pend_valid_r && (pend_page_r == cur_page_r) && (pend_bar_r == bar_r) &&
                (pend_len_r != 8'hFF) && (col_sum == {1'b0, cur_col_r});
    room      = span_cnt_r < 4'(rbsd_pkg::SPAN_CAP);
    start_new = visible && !merge && room;
    step_emit = start_new && pend_valid_r;
    col_inc   = cur_col_r + 8'd1;
    col_off   = col_inc - base_col_r;
    wrap      = col_off >= img_width_r;
    page_off  = cur_page_r - base_page_r;
    done_now  = boundary_r && (page_off >= img_pages_r);
    flush_emit = pend_valid_r || done_now;
    out_free  = !out_valid_r || out_ready;
    lit_dec   = literal_left_r - 7'd1;

    sts.no_bars  = (bars_left_r == 7'd0);
    sts.last_bar = (bars_left_r == 7'd1);
    sts.step_ok  = !step_emit || out_free;
    sts.flush_ok = !flush_emit || out_free;

    phase_eff = (cmd.flush && done_now) ? PH_IDLE : phase_r;

    emit = (cmd.step && step_emit) || (cmd.flush && flush_emit);
    emit_word.span_page    = pend_valid_r ? pend_page_r[2:0] : 3'd0;
    emit_word.span_col     = pend_valid_r ? pend_col_r[6:0] : 7'd0;
    emit_word.span_len     = pend_valid_r ? pend_len_r : 8'd0;
    emit_word.bar_value    = pend_valid_r ? pend_bar_r : 8'd0;
    emit_word.image_done   = cmd.flush && done_now;
    emit_word.image_width  = (cmd.flush && done_now) ? img_width_r : 8'd0;
    emit_word.last_of_byte = cmd.flush;
  end

  // decode state and bar walk
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      img_width_r    <= 8'd0;
      img_pages_r    <= 8'd0;
      base_col_r     <= 8'd0;
      base_page_r    <= 8'd0;
      cur_col_r      <= 8'd0;
      cur_page_r     <= 8'd0;
      literal_left_r <= 7'd0;
      run_count_r    <= 7'd0;
      bars_left_r    <= 7'd0;
      bar_r          <= 8'd0;
      boundary_r     <= 1'b0;
      pend_valid_r   <= 1'b0;
      span_cnt_r     <= 4'd0;
    end else begin
      if (cmd.flush) begin
        pend_valid_r <= 1'b0;
        span_cnt_r   <= 4'd0;
        if (done_now && !cmd.load) phase_r <= PH_IDLE;
      end
      if (cmd.step) begin
        bars_left_r <= bars_left_r - 7'd1;
        if (start_new) begin
          pend_valid_r <= 1'b1;
          span_cnt_r   <= span_cnt_r + 4'd1;
        end
        if (wrap) begin
          cur_page_r <= cur_page_r + 8'd1;
          cur_col_r  <= base_col_r;
        end else begin
          cur_col_r <= col_inc;
        end
      end
      if (cmd.load) begin
        bars_left_r <= 7'd0;
        boundary_r  <= 1'b0;
        if (in_word.image_start) begin
          base_col_r     <= in_word.origin_col;
          base_page_r    <= in_word.origin_page;
          cur_col_r      <= in_word.origin_col;
          cur_page_r     <= in_word.origin_page;
          img_width_r    <= in_word.in_byte;
          img_pages_r    <= 8'd0;
          literal_left_r <= 7'd0;
          run_count_r    <= 7'd0;
          phase_r        <= PH_PAGES;
        end else begin
          case (phase_eff)
            PH_PAGES: begin
              img_pages_r <= in_word.in_byte;
              boundary_r  <= 1'b1;
              phase_r     <= PH_TOKEN;
            end
            PH_TOKEN: begin
              if (in_word.in_byte[7]) begin
                run_count_r <= in_word.in_byte[6:0];
                phase_r     <= PH_RUNBYTE;
              end else if (in_word.in_byte == 8'd0) begin
                boundary_r <= 1'b1;
                phase_r    <= PH_TOKEN;
              end else begin
                literal_left_r <= in_word.in_byte[6:0];
                phase_r        <= PH_LITERAL;
              end
            end
            PH_RUNBYTE: begin
              bars_left_r <= run_count_r;
              bar_r       <= in_word.in_byte;
              run_count_r <= 7'd0;
              boundary_r  <= 1'b1;
              phase_r     <= PH_TOKEN;
            end
            PH_LITERAL: begin
              bars_left_r    <= 7'd1;
              bar_r          <= in_word.in_byte;
              literal_left_r <= lit_dec;
              if (lit_dec == 7'd0) begin
                boundary_r <= 1'b1;
                phase_r    <= PH_TOKEN;
              end
            end
            default: phase_r <= PH_IDLE;
          endcase
        end
      end
    end
  end

  // pending span payload
  always_ff @(posedge clk) begin
    if (cmd.step && visible) begin
      if (start_new) begin
        pend_page_r <= cur_page_r;
        pend_col_r  <= cur_col_r;
        pend_len_r  <= 8'd1;
        pend_bar_r  <= bar_r;
      end else if (merge) begin
        pend_len_r <= pend_len_r + 8'd1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_word_r <= emit_word;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_valid_r) |-> out_ready) else $error("output word overwritten");

  a_pend_len: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (pend_len_r != 8'd0)) else $error("empty pending span");

  a_bare_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.span_len == 8'd0) |->
      (out_word_r.image_done && out_word_r.last_of_byte))
    else $error("zero-length span without done");

endmodule

// File: sv/rle_bitmap_span_decoder_core.sv
// Run-length bitmap span decoder. Takes one coded byte per input word (header
// bytes first, the first of them flagged by image_start) and returns the
// visible bar spans that each byte draws, the final span of a byte flagged
// last_of_byte and, at the end of an image, image_done with the width. Each
// byte is loaded, then the datapath walks its bars one bar per cycle, merging
// bars into the open span, and then issues the byte's last span. A bar that
// opens a new span waits only while the output register holds a word that
// has not been taken; the next byte is accepted in the cycle the last span of
// the current byte is issued.
module rle_bitmap_span_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rbsd_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output rbsd_pkg::out_word_t out_word
);

  rbsd_pkg::ctrl_cmd_t cmd;
  rbsd_pkg::ctrl_sts_t sts;

  rbsd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbsd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

endmodule
